### src/line_intersection_defines.svh
// Assertion macros shared by the line intersection RTL.
`ifndef LINE_INTERSECTION_DEFINES_SVH
`define LINE_INTERSECTION_DEFINES_SVH

// same-cycle implication, disabled in reset
`define LI_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication failed");

// next-cycle implication, disabled in reset
`define LI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

### src/li_pkg.sv
// Shared constants and types for the line intersection block.
package li_pkg;
    localparam int LI_COORD_WIDTH = 16;
    localparam int LI_THR_WIDTH   = 33;
    localparam int LI_OUT_WIDTH   = 32;
    localparam logic [LI_THR_WIDTH-1:0] LI_THR_RESET = 33'd1;
    localparam logic [LI_OUT_WIDTH-1:0] LI_OUT_MAX   = 32'h7FFF_FFFF;
    localparam logic [LI_OUT_WIDTH-1:0] LI_OUT_MIN   = 32'h8000_0000;

    typedef struct packed {
        logic par;
        logic neg_x;
        logic neg_y;
        logic over_x;
        logic over_y;
    } li_flags_t;
endpackage

### src/line_intersection.sv
// Top level: line pair intersection by Cramer's rule, fully pipelined.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-----------------------------------
//  in       | in_valid / in_stall        | first_*, second_* endpoints
//  out      | out_valid / out_stall      | cross_x, cross_y, parallel, saturated
//  cfg      | cfg_wr_en (no wait)        | cfg_wr_data -> parallel_threshold
//
// One request per cycle sustained while in_stall is low; the pipe is 6 front stages
// (coefficients, products, c and det, numerator products, numerators,
// magnitudes), 32 divider cells (one quotient bit each), one output register.
// The whole pipe advances together whenever the output register is empty or
// taken; in_stall is asserted only while a finished result waits under
// out_stall. Reset clears the valid bits and sets the threshold to 1.
`include "line_intersection_defines.svh"
module line_intersection
    import li_pkg::*;
#(
    parameter int COORD_WIDTH = LI_COORD_WIDTH
)(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [LI_THR_WIDTH-1:0]        cfg_wr_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic signed [COORD_WIDTH-1:0]  first_begin_x,
    input  logic signed [COORD_WIDTH-1:0]  first_begin_y,
    input  logic signed [COORD_WIDTH-1:0]  first_end_x,
    input  logic signed [COORD_WIDTH-1:0]  first_end_y,
    input  logic signed [COORD_WIDTH-1:0]  second_begin_x,
    input  logic signed [COORD_WIDTH-1:0]  second_begin_y,
    input  logic signed [COORD_WIDTH-1:0]  second_end_x,
    input  logic signed [COORD_WIDTH-1:0]  second_end_y,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [LI_OUT_WIDTH-1:0] cross_x,
    output logic signed [LI_OUT_WIDTH-1:0] cross_y,
    output logic                           parallel,
    output logic                           saturated
);
    localparam int DETW = 2 * COORD_WIDTH + 3;
    localparam int RW   = DETW + LI_OUT_WIDTH;
    localparam int QB   = LI_OUT_WIDTH;

    logic [LI_THR_WIDTH-1:0] thr_reg;
    logic en;

    // divider chain taps: index k feeds cell for quotient bit QB-1-k
    logic            cv [0:QB];
    logic [RW-1:0]   crx [0:QB];
    logic [RW-1:0]   cry [0:QB];
    logic [DETW-1:0] cd [0:QB];
    logic [QB-1:0]   cqx [0:QB];
    logic [QB-1:0]   cqy [0:QB];
    li_flags_t       cf [0:QB];

    logic                    ov_reg;
    logic [LI_OUT_WIDTH-1:0] x_reg, y_reg, x_next, y_next;
    logic                    par_reg, sat_reg, sx, sy;

    // pipe moves when the output slot is free or being taken
    assign en       = !ov_reg || !out_stall;
    assign in_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= LI_THR_RESET;
        end
        else if (cfg_wr_en)
        begin
            thr_reg <= cfg_wr_data;
        end
    end

    li_front #(.CW(COORD_WIDTH)) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .in_v  (in_valid),
        .p1x   (first_begin_x),
        .p1y   (first_begin_y),
        .q1x   (first_end_x),
        .q1y   (first_end_y),
        .p2x   (second_begin_x),
        .p2y   (second_begin_y),
        .q2x   (second_end_x),
        .q2y   (second_end_y),
        .thr   (thr_reg),
        .out_v (cv[0]),
        .rem_x (crx[0]),
        .rem_y (cry[0]),
        .dmag  (cd[0]),
        .flags (cf[0])
    );

    assign cqx[0] = '0;
    assign cqy[0] = '0;

    for (genvar k = 0; k < QB; k++)
    begin : g_cell
        li_cell #(.DETW(DETW), .BIT(QB - 1 - k)) u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .en     (en),
            .v_in   (cv[k]),
            .rx_in  (crx[k]),
            .ry_in  (cry[k]),
            .d_in   (cd[k]),
            .qx_in  (cqx[k]),
            .qy_in  (cqy[k]),
            .f_in   (cf[k]),
            .v_out  (cv[k+1]),
            .rx_out (crx[k+1]),
            .ry_out (cry[k+1]),
            .d_out  (cd[k+1]),
            .qx_out (cqx[k+1]),
            .qy_out (cqy[k+1]),
            .f_out  (cf[k+1])
        );
    end

    // sign and clamp; remainders and divisor past the last cell are not needed
    always_comb
    begin
        sx = 1'b0;
        sy = 1'b0;
        if (cf[QB].neg_x)
        begin
            if (cf[QB].over_x || cqx[QB] > LI_OUT_MIN)
            begin
                x_next = LI_OUT_MIN;
                sx     = 1'b1;
            end
            else
            begin
                x_next = ~cqx[QB] + 1'b1;
            end
        end
        else if (cf[QB].over_x || cqx[QB] > LI_OUT_MAX)
        begin
            x_next = LI_OUT_MAX;
            sx     = 1'b1;
        end
        else
        begin
            x_next = cqx[QB];
        end
        if (cf[QB].neg_y)
        begin
            if (cf[QB].over_y || cqy[QB] > LI_OUT_MIN)
            begin
                y_next = LI_OUT_MIN;
                sy     = 1'b1;
            end
            else
            begin
                y_next = ~cqy[QB] + 1'b1;
            end
        end
        else if (cf[QB].over_y || cqy[QB] > LI_OUT_MAX)
        begin
            y_next = LI_OUT_MAX;
            sy     = 1'b1;
        end
        else
        begin
            y_next = cqy[QB];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else if (en)
        begin
            ov_reg <= cv[QB];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            par_reg <= cf[QB].par;
            x_reg   <= cf[QB].par ? LI_OUT_MAX : x_next;
            y_reg   <= cf[QB].par ? LI_OUT_MAX : y_next;
            sat_reg <= !cf[QB].par && (sx || sy);
        end
    end

    assign out_valid = ov_reg;
    assign cross_x   = x_reg;
    assign cross_y   = y_reg;
    assign parallel  = par_reg;
    assign saturated = sat_reg;

    `LI_ASSERT_IMPLY(a_par_no_sat, clk, rst_n, out_valid && parallel, !saturated)
    `LI_ASSERT_IMPLY(a_par_max, clk, rst_n, out_valid && parallel,
        cross_x == LI_OUT_MAX && cross_y == LI_OUT_MAX)
    `LI_ASSERT_IMPLY(a_sat_clamp, clk, rst_n, out_valid && saturated,
        cross_x == LI_OUT_MAX || cross_x == LI_OUT_MIN ||
        cross_y == LI_OUT_MAX || cross_y == LI_OUT_MIN)
    `LI_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(cross_x))
endmodule

### src/li_front.sv
// Front pipeline: line coefficients, determinant, numerators, magnitudes.
module li_front
    import li_pkg::*;
#(
    parameter int CW = LI_COORD_WIDTH
)(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_v,
    input  logic signed [CW-1:0]        p1x,
    input  logic signed [CW-1:0]        p1y,
    input  logic signed [CW-1:0]        q1x,
    input  logic signed [CW-1:0]        q1y,
    input  logic signed [CW-1:0]        p2x,
    input  logic signed [CW-1:0]        p2y,
    input  logic signed [CW-1:0]        q2x,
    input  logic signed [CW-1:0]        q2y,
    input  logic [LI_THR_WIDTH-1:0]     thr,
    output logic                        out_v,
    output logic [2*CW+3+LI_OUT_WIDTH-1:0] rem_x,
    output logic [2*CW+3+LI_OUT_WIDTH-1:0] rem_y,
    output logic [2*CW+3-1:0]           dmag,
    output li_flags_t                   flags
);
    localparam int AW   = CW + 1;
    localparam int PW   = AW + CW;
    localparam int CTW  = PW + 1;
    localparam int DETW = 2 * AW + 1;
    localparam int NPW  = AW + CTW;
    localparam int NUMW = NPW + 1;
    localparam int RW   = DETW + LI_OUT_WIDTH;
    localparam int CMPW = (DETW > LI_THR_WIDTH) ? DETW : LI_THR_WIDTH;

    logic [5:0] v_reg;
    logic [5:0] v_next;

    // stage A
    logic signed [AW-1:0] a1_reg, b1_reg, a2_reg, b2_reg;
    logic signed [CW-1:0] x1_reg, y1_reg, x2_reg, y2_reg;
    // stage B
    logic signed [AW-1:0] a1b_reg, b1b_reg, a2b_reg, b2b_reg;
    logic signed [PW-1:0] m1_reg, m2_reg, m3_reg, m4_reg;
    logic signed [2*AW-1:0] d1_reg, d2_reg;
    // stage C
    logic signed [AW-1:0] a1c_reg, b1c_reg, a2c_reg, b2c_reg;
    logic signed [CTW-1:0] c1_reg, c2_reg;
    logic signed [DETW-1:0] detc_reg;
    // stage D
    logic signed [NPW-1:0] n1_reg, n2_reg, n3_reg, n4_reg;
    logic signed [DETW-1:0] detd_reg;
    // stage E
    logic signed [NUMW-1:0] numx_reg, numy_reg;
    logic signed [DETW-1:0] dete_reg;
    // stage F
    logic [RW-1:0]   remx_reg, remy_reg;
    logic [DETW-1:0] dmag_reg;
    li_flags_t       flags_reg;

    logic [NUMW-1:0] absx, absy;
    logic [DETW-1:0] dabs;
    logic [RW-1:0]   dshift;

    always_comb
    begin
        v_next = {v_reg[4:0], in_v};
        absx   = numx_reg[NUMW-1] ? (~numx_reg + 1'b1) : numx_reg;
        absy   = numy_reg[NUMW-1] ? (~numy_reg + 1'b1) : numy_reg;
        dabs   = dete_reg[DETW-1] ? (~dete_reg + 1'b1) : dete_reg;
        dshift = RW'(dabs) << LI_OUT_WIDTH;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a1_reg <= AW'(q1y) - AW'(p1y);
            b1_reg <= AW'(p1x) - AW'(q1x);
            a2_reg <= AW'(q2y) - AW'(p2y);
            b2_reg <= AW'(p2x) - AW'(q2x);
            x1_reg <= p1x;
            y1_reg <= p1y;
            x2_reg <= p2x;
            y2_reg <= p2y;

            a1b_reg <= a1_reg;
            b1b_reg <= b1_reg;
            a2b_reg <= a2_reg;
            b2b_reg <= b2_reg;
            m1_reg  <= PW'(a1_reg) * PW'(x1_reg);
            m2_reg  <= PW'(b1_reg) * PW'(y1_reg);
            m3_reg  <= PW'(a2_reg) * PW'(x2_reg);
            m4_reg  <= PW'(b2_reg) * PW'(y2_reg);
            d1_reg  <= (2*AW)'(a1_reg) * (2*AW)'(b2_reg);
            d2_reg  <= (2*AW)'(a2_reg) * (2*AW)'(b1_reg);

            a1c_reg  <= a1b_reg;
            b1c_reg  <= b1b_reg;
            a2c_reg  <= a2b_reg;
            b2c_reg  <= b2b_reg;
            c1_reg   <= CTW'(m1_reg) + CTW'(m2_reg);
            c2_reg   <= CTW'(m3_reg) + CTW'(m4_reg);
            detc_reg <= DETW'(d1_reg) - DETW'(d2_reg);

            n1_reg   <= NPW'(b2c_reg) * NPW'(c1_reg);
            n2_reg   <= NPW'(b1c_reg) * NPW'(c2_reg);
            n3_reg   <= NPW'(a1c_reg) * NPW'(c2_reg);
            n4_reg   <= NPW'(a2c_reg) * NPW'(c1_reg);
            detd_reg <= detc_reg;

            numx_reg <= NUMW'(n1_reg) - NUMW'(n2_reg);
            numy_reg <= NUMW'(n3_reg) - NUMW'(n4_reg);
            dete_reg <= detd_reg;

            remx_reg         <= RW'(absx);
            remy_reg         <= RW'(absy);
            dmag_reg         <= dabs;
            // zero det always counts as parallel
            flags_reg.par    <= (dabs == '0) || (CMPW'(dabs) < CMPW'(thr));
            flags_reg.neg_x  <= numx_reg[NUMW-1] ^ dete_reg[DETW-1];
            flags_reg.neg_y  <= numy_reg[NUMW-1] ^ dete_reg[DETW-1];
            flags_reg.over_x <= RW'(absx) >= dshift;
            flags_reg.over_y <= RW'(absy) >= dshift;
        end
    end

    assign out_v = v_reg[5];
    assign rem_x = remx_reg;
    assign rem_y = remy_reg;
    assign dmag  = dmag_reg;
    assign flags = flags_reg;
endmodule

### src/li_cell.sv
// One restoring-division cell: settles one quotient bit of both coordinates.
module li_cell
    import li_pkg::*;
#(
    parameter int DETW = 35,
    parameter int BIT  = 0
)(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              v_in,
    input  logic [DETW+LI_OUT_WIDTH-1:0]      rx_in,
    input  logic [DETW+LI_OUT_WIDTH-1:0]      ry_in,
    input  logic [DETW-1:0]                   d_in,
    input  logic [LI_OUT_WIDTH-1:0]           qx_in,
    input  logic [LI_OUT_WIDTH-1:0]           qy_in,
    input  li_flags_t                         f_in,
    output logic                              v_out,
    output logic [DETW+LI_OUT_WIDTH-1:0]      rx_out,
    output logic [DETW+LI_OUT_WIDTH-1:0]      ry_out,
    output logic [DETW-1:0]                   d_out,
    output logic [LI_OUT_WIDTH-1:0]           qx_out,
    output logic [LI_OUT_WIDTH-1:0]           qy_out,
    output li_flags_t                         f_out
);
    localparam int RW = DETW + LI_OUT_WIDTH;

    logic          v_reg;
    logic [RW-1:0] rx_reg, ry_reg, dsh;
    logic [DETW-1:0] d_reg;
    logic [LI_OUT_WIDTH-1:0] qx_reg, qy_reg;
    logic [LI_OUT_WIDTH-1:0] qx_next, qy_next;
    li_flags_t     f_reg;
    logic          gx, gy;

    always_comb
    begin
        dsh = RW'(d_in) << BIT;
        gx  = rx_in >= dsh;
        gy  = ry_in >= dsh;
        qx_next      = qx_in;
        qy_next      = qy_in;
        qx_next[BIT] = gx;
        qy_next[BIT] = gy;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg <= v_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rx_reg <= gx ? rx_in - dsh : rx_in;
            ry_reg <= gy ? ry_in - dsh : ry_in;
            qx_reg <= qx_next;
            qy_reg <= qy_next;
            d_reg  <= d_in;
            f_reg  <= f_in;
        end
    end

    assign v_out  = v_reg;
    assign rx_out = rx_reg;
    assign ry_out = ry_reg;
    assign d_out  = d_reg;
    assign qx_out = qx_reg;
    assign qy_out = qy_reg;
    assign f_out  = f_reg;
endmodule
